>>> design/sgps_pkg.sv
`default_nettype none

package sgps_pkg;

	// fixed widths of the register file and payload
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned SCALE_W = 3;
	localparam int unsigned GLYPH_W = 5;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned BITS_W  = 16;

	localparam int unsigned MAX_GLYPH_BITS_DEF = 16;
	localparam int unsigned MAX_SCALE_DEF      = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TEXT_COLOR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_BACK_COLOR   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCALE        = 3'd2;
	localparam logic [IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd4;

	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST   = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RST   = 16'h0000;
	localparam logic [SCALE_W-1:0] SCALE_RST        = 3'd1;
	localparam logic [GLYPH_W-1:0] GLYPH_WIDTH_RST  = 5'd8;
	localparam logic [GLYPH_W-1:0] GLYPH_HEIGHT_RST = 5'd16;

	// input commands
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_ROW   = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PARAM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

	// controller opcodes
	localparam logic [BYTE_W-1:0] OP_ROW_SET   = 8'h2B;
	localparam logic [BYTE_W-1:0] OP_COL_SET   = 8'h2A;
	localparam logic [BYTE_W-1:0] OP_MEM_WRITE = 8'h2C;

	// operands of the shared multiply-add: a + b*c - dec
	typedef struct packed {
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [POS_W-1:0]  c;
		logic              dec;
	} madd_op_t;

endpackage

`default_nettype wire

>>> design/sgps_madd.sv
`default_nettype none

module sgps_madd (
	input  wire logic                            clk,
	input  wire sgps_pkg::madd_op_t              op,
	output logic     [sgps_pkg::ADDR_W-1:0]      res_q
);

	logic [sgps_pkg::ADDR_W+sgps_pkg::POS_W-1:0] prod;
	logic [sgps_pkg::ADDR_W-1:0]                 sum;

	assign prod = op.b * op.c;
	// everything wraps to 16 bits
	assign sum  = op.a + prod[sgps_pkg::ADDR_W-1:0]
		- {{(sgps_pkg::ADDR_W-1){1'b0}}, op.dec};

	always_ff @(posedge clk) begin
		res_q <= sum;
	end

endmodule

`default_nettype wire

>>> design/scaled_glyph_pixel_streamer_top.sv
`default_nettype none

// channel   | ports                                              | handshake
// ----------+----------------------------------------------------+------------------------
// item in   | command x_origin y_origin char_position glyph_bits | start while busy is low
// result    | kind byte_value pixel_color repeat_res last        | strobe, one cycle
// config    | wr_index wr_data                                   | wr_en, any cycle
//
// begin item: the window addresses go through the shared multiply-add unit first,
// then 11 beats at one a cycle
// glyph-row item: scale*glyph_width beats at one a cycle, up to 64
// busy is high from the cycle after start until the last beat is on the ports
// arst_n clears the registers to their reset values and the sequencer to idle
// the receiver cannot stall: every beat is taken in the cycle it is shown

module scaled_glyph_pixel_streamer_top #(
	parameter int unsigned MAX_GLYPH_BITS = sgps_pkg::MAX_GLYPH_BITS_DEF,
	parameter int unsigned MAX_SCALE      = sgps_pkg::MAX_SCALE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic [sgps_pkg::ADDR_W-1:0]   x_origin,
	input  wire logic [sgps_pkg::ADDR_W-1:0]   y_origin,
	input  wire logic [sgps_pkg::POS_W-1:0]    char_position,
	input  wire logic [sgps_pkg::BITS_W-1:0]   glyph_bits,
	input  wire logic                          wr_en,
	input  wire logic [sgps_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [sgps_pkg::DATA_W-1:0]   wr_data,
	output logic                               strobe,
	output logic      [sgps_pkg::KIND_W-1:0]   kind,
	output logic      [sgps_pkg::BYTE_W-1:0]   byte_value,
	output logic      [sgps_pkg::COLOR_W-1:0]  pixel_color,
	output logic      [sgps_pkg::SCALE_W-1:0]  repeat_res,
	output logic                               last
);

	localparam logic [sgps_pkg::SCALE_W-1:0] SCALE_MAX = sgps_pkg::SCALE_W'(MAX_SCALE);
	localparam logic [sgps_pkg::GLYPH_W-1:0] GLYPH_MAX = sgps_pkg::GLYPH_W'(MAX_GLYPH_BITS);
	localparam int unsigned HDR_BEATS = 11;
	localparam int unsigned HDR_W     = $clog2(HDR_BEATS);
	localparam int unsigned CALC_W    = 3;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_HDR  = 4'b0100,
		ST_PIX  = 4'b1000
	} state_t;

	state_t state_q;

	// register file
	logic [sgps_pkg::COLOR_W-1:0] text_color_q;
	logic [sgps_pkg::COLOR_W-1:0] back_color_q;
	logic [sgps_pkg::SCALE_W-1:0] scale_q;
	logic [sgps_pkg::GLYPH_W-1:0] glyph_width_q;
	logic [sgps_pkg::GLYPH_W-1:0] glyph_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q   <= sgps_pkg::TEXT_COLOR_RST;
			back_color_q   <= sgps_pkg::BACK_COLOR_RST;
			scale_q        <= sgps_pkg::SCALE_RST;
			glyph_width_q  <= sgps_pkg::GLYPH_WIDTH_RST;
			glyph_height_q <= sgps_pkg::GLYPH_HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				sgps_pkg::REG_TEXT_COLOR:   text_color_q   <= wr_data;
				sgps_pkg::REG_BACK_COLOR:   back_color_q   <= wr_data;
				sgps_pkg::REG_SCALE:        scale_q        <= wr_data[sgps_pkg::SCALE_W-1:0];
				sgps_pkg::REG_GLYPH_WIDTH:  glyph_width_q  <= wr_data[sgps_pkg::GLYPH_W-1:0];
				sgps_pkg::REG_GLYPH_HEIGHT: glyph_height_q <= wr_data[sgps_pkg::GLYPH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped sizes
	logic [sgps_pkg::SCALE_W-1:0] s_c;
	logic [sgps_pkg::GLYPH_W-1:0] w_c;
	logic [sgps_pkg::GLYPH_W-1:0] h_c;

	always_comb begin
		s_c = scale_q;
		if (scale_q == '0) s_c = sgps_pkg::SCALE_W'(1);
		else if (scale_q > SCALE_MAX) s_c = SCALE_MAX;
		w_c = glyph_width_q;
		if (glyph_width_q == '0) w_c = sgps_pkg::GLYPH_W'(1);
		else if (glyph_width_q > GLYPH_MAX) w_c = GLYPH_MAX;
		h_c = glyph_height_q;
		if (glyph_height_q == '0) h_c = sgps_pkg::GLYPH_W'(1);
		else if (glyph_height_q > GLYPH_MAX) h_c = GLYPH_MAX;
	end

	// latched item
	logic [sgps_pkg::ADDR_W-1:0]  x0_q;
	logic [sgps_pkg::ADDR_W-1:0]  y0_q;
	logic [sgps_pkg::POS_W-1:0]   pos_q;
	logic [sgps_pkg::BITS_W-1:0]  bits_q;
	logic [sgps_pkg::SCALE_W-1:0] s_q;
	logic [sgps_pkg::GLYPH_W-1:0] w_q;
	logic [sgps_pkg::GLYPH_W-1:0] h_q;

	// window results
	logic [sgps_pkg::ADDR_W-1:0] x_end_q;
	logic [sgps_pkg::ADDR_W-1:0] ws_q;
	logic [sgps_pkg::ADDR_W-1:0] y_start_q;
	logic [sgps_pkg::ADDR_W-1:0] y_end_q;

	logic [CALC_W-1:0]           calc_q;
	logic [HDR_W-1:0]            hdr_q;
	logic [sgps_pkg::SCALE_W-1:0] pass_q;
	logic [sgps_pkg::GLYPH_W-1:0] col_q;
	logic [sgps_pkg::BITS_W-1:0]  shift_q;

	sgps_pkg::madd_op_t          op;
	logic [sgps_pkg::ADDR_W-1:0] madd_res;

	sgps_madd u_madd (
		.clk   (clk),
		.op    (op),
		.res_q (madd_res)
	);

	// step 0 x end, 1 width*scale, 2 y start, 3 y end; each result lands in the next cycle
	always_comb begin
		op = '{a: '0, b: '0, c: '0, dec: 1'b0};
		case (calc_q)
			CALC_W'(0): op = '{a: x0_q, b: sgps_pkg::ADDR_W'(h_q),
				c: sgps_pkg::POS_W'(s_q), dec: 1'b1};
			CALC_W'(1): op = '{a: '0, b: sgps_pkg::ADDR_W'(w_q),
				c: sgps_pkg::POS_W'(s_q), dec: 1'b0};
			CALC_W'(2): op = '{a: y0_q, b: madd_res, c: pos_q, dec: 1'b0};
			CALC_W'(3): op = '{a: madd_res, b: ws_q,
				c: sgps_pkg::POS_W'(1), dec: 1'b1};
			default: ;
		endcase
	end

	// glyph row left-aligned so the first pixel sits at the top bit
	function automatic logic [sgps_pkg::BITS_W-1:0] align_row(
		input logic [sgps_pkg::BITS_W-1:0] b,
		input logic [sgps_pkg::GLYPH_W-1:0] w
	);
		logic [sgps_pkg::GLYPH_W-1:0] sh;
		sh = sgps_pkg::GLYPH_W'(sgps_pkg::BITS_W) - w;
		return b << sh;
	endfunction

	// header beat
	logic [sgps_pkg::KIND_W-1:0] hdr_kind;
	logic [sgps_pkg::BYTE_W-1:0] hdr_byte;

	always_comb begin
		hdr_kind = sgps_pkg::KIND_PARAM;
		case (hdr_q)
			HDR_W'(0): begin
				hdr_kind = sgps_pkg::KIND_CMD;
				hdr_byte = sgps_pkg::OP_ROW_SET;
			end
			HDR_W'(1): hdr_byte = x0_q[15:8];
			HDR_W'(2): hdr_byte = x0_q[7:0];
			HDR_W'(3): hdr_byte = x_end_q[15:8];
			HDR_W'(4): hdr_byte = x_end_q[7:0];
			HDR_W'(5): begin
				hdr_kind = sgps_pkg::KIND_CMD;
				hdr_byte = sgps_pkg::OP_COL_SET;
			end
			HDR_W'(6): hdr_byte = y_start_q[15:8];
			HDR_W'(7): hdr_byte = y_start_q[7:0];
			HDR_W'(8): hdr_byte = y_end_q[15:8];
			HDR_W'(9): hdr_byte = y_end_q[7:0];
			default: begin
				hdr_kind = sgps_pkg::KIND_CMD;
				hdr_byte = sgps_pkg::OP_MEM_WRITE;
			end
		endcase
	end

	logic hdr_done;
	logic col_done;
	logic pass_done;

	assign hdr_done  = (hdr_q == HDR_W'(HDR_BEATS - 1));
	assign col_done  = (col_q == w_q - sgps_pkg::GLYPH_W'(1));
	assign pass_done = (pass_q == s_q - sgps_pkg::SCALE_W'(1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			calc_q  <= '0;
			hdr_q   <= '0;
			pass_q  <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					calc_q <= '0;
					hdr_q  <= '0;
					pass_q <= '0;
					col_q  <= '0;
					if (start) begin
						state_q <= (command == sgps_pkg::CMD_ROW) ? ST_PIX : ST_CALC;
					end
				end
				ST_CALC: begin
					calc_q <= calc_q + CALC_W'(1);
					if (calc_q == CALC_W'(4)) state_q <= ST_HDR;
				end
				ST_HDR: begin
					hdr_q <= hdr_q + HDR_W'(1);
					if (hdr_done) state_q <= ST_IDLE;
				end
				ST_PIX: begin
					if (col_done) begin
						col_q  <= '0;
						pass_q <= pass_q + sgps_pkg::SCALE_W'(1);
						if (pass_done) state_q <= ST_IDLE;
					end else begin
						col_q <= col_q + sgps_pkg::GLYPH_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and window datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x0_q    <= x_origin;
			y0_q    <= y_origin;
			pos_q   <= char_position;
			bits_q  <= glyph_bits;
			s_q     <= s_c;
			w_q     <= w_c;
			h_q     <= h_c;
			shift_q <= align_row(glyph_bits, w_c);
		end else if (state_q == ST_PIX) begin
			shift_q <= col_done ? align_row(bits_q, w_q) : (shift_q << 1);
		end
		if (state_q == ST_CALC) begin
			case (calc_q)
				CALC_W'(1): x_end_q   <= madd_res;
				CALC_W'(2): ws_q      <= madd_res;
				CALC_W'(3): y_start_q <= madd_res;
				CALC_W'(4): y_end_q   <= madd_res;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			last   <= 1'b0;
		end else begin
			strobe <= (state_q == ST_HDR) || (state_q == ST_PIX);
			last   <= ((state_q == ST_HDR) && hdr_done)
				|| ((state_q == ST_PIX) && col_done && pass_done);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PIX) begin
			kind        <= sgps_pkg::KIND_PIXEL;
			byte_value  <= '0;
			pixel_color <= shift_q[sgps_pkg::BITS_W-1] ? text_color_q : back_color_q;
			repeat_res  <= s_q;
		end else begin
			kind        <= hdr_kind;
			byte_value  <= hdr_byte;
			pixel_color <= '0;
			repeat_res  <= '0;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// the final beat of an item goes out as the sequencer returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("last beat shown while still busy");

	// a beat seen while idle can only be the closing one
	a_idle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && strobe |-> last)
		else $error("non-final beat while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == sgps_pkg::KIND_PIXEL |->
			repeat_res != '0 && repeat_res <= SCALE_MAX)
		else $error("pixel run length outside scale range");

	a_hdr_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != sgps_pkg::KIND_PIXEL |-> repeat_res == '0 && pixel_color == '0)
		else $error("header beat carries pixel data");

endmodule

`default_nettype wire

>>> test/scaled_glyph_pixel_streamer_top_test.sv
`timescale 1ns / 100ps

module scaled_glyph_pixel_streamer_top_test;
	import sgps_pkg::*;

	localparam int unsigned SCALE_MAX    = MAX_SCALE_DEF;
	localparam int unsigned GLYPH_MAX    = MAX_GLYPH_BITS_DEF;
	localparam int unsigned SETTLE_TICKS = 20;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned RANDOM_ITEMS = 390;
	localparam int unsigned PHASE_ITEMS  = 40;
	localparam logic [IDX_W-1:0] REG_BEYOND = 3'd5;

	typedef enum logic [1:0] {ACT_ITEM, ACT_REG_WRITE, ACT_SETTLE} glyph_act_e;

	typedef struct {
		glyph_act_e         act;
		logic               cmd;
		logic [ADDR_W-1:0]  x0;
		logic [ADDR_W-1:0]  y0;
		logic [POS_W-1:0]   pos;
		logic [BITS_W-1:0]  bits;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  data;
		int unsigned        gap;
	} glyph_act_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  byte_value;
		logic [COLOR_W-1:0] color;
		logic [SCALE_W-1:0] rep;
		logic               fin;
	} stream_beat_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                command = 1'b0;
	logic [ADDR_W-1:0]   x_origin = '0;
	logic [ADDR_W-1:0]   y_origin = '0;
	logic [POS_W-1:0]    char_position = '0;
	logic [BITS_W-1:0]   glyph_bits = '0;
	logic                wr_en = 1'b0;
	logic [IDX_W-1:0]    wr_index = '0;
	logic [DATA_W-1:0]   wr_data = '0;
	logic                strobe;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   byte_value;
	logic [COLOR_W-1:0]  pixel_color;
	logic [SCALE_W-1:0]  repeat_res;
	logic                last;

	// predictor's copy of the register file
	logic [COLOR_W-1:0]  cfg_text = TEXT_COLOR_RST;
	logic [COLOR_W-1:0]  cfg_back = BACK_COLOR_RST;
	logic [SCALE_W-1:0]  cfg_scale = SCALE_RST;
	logic [GLYPH_W-1:0]  cfg_width = GLYPH_WIDTH_RST;
	logic [GLYPH_W-1:0]  cfg_height = GLYPH_HEIGHT_RST;

	glyph_act_t          glyph_work_q[$];
	stream_beat_t        display_stream_q[$];
	glyph_act_t          step_now;
	stream_beat_t        want_beat;
	stream_beat_t        got_beat;
	logic                item_took = 1'b0;
	logic                feed_done = 1'b0;
	int unsigned         idle_left = 0;
	int unsigned         settle_cnt = 0;
	int unsigned         stall_cycles = 0;
	int unsigned         gen_height = GLYPH_HEIGHT_RST;
	int unsigned         items_taken = 0;
	int unsigned         windows_taken = 0;
	int unsigned         rows_taken = 0;
	int unsigned         beats_checked = 0;
	int unsigned         writes_taken = 0;
	int unsigned         errors = 0;

	scaled_glyph_pixel_streamer_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void push_beat(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
			logic [COLOR_W-1:0] c, logic [SCALE_W-1:0] r, logic fin);
		display_stream_q.push_back(stream_beat_t'{k, b, c, r, fin});
	endfunction

	function automatic void render_window(logic [ADDR_W-1:0] x0, logic [ADDR_W-1:0] y0,
			logic [POS_W-1:0] pos);
		int unsigned s;
		int unsigned w;
		int unsigned h;
		logic [ADDR_W-1:0] x_end;
		logic [ADDR_W-1:0] y_first;
		logic [ADDR_W-1:0] y_end;
		s = clamp_cfg(cfg_scale, SCALE_MAX);
		w = clamp_cfg(cfg_width, GLYPH_MAX);
		h = clamp_cfg(cfg_height, GLYPH_MAX);
		// all three addresses wrap at 16 bits
		x_end   = ADDR_W'(x0 + h * s - 1);
		y_first = ADDR_W'(y0 + w * pos * s);
		y_end   = ADDR_W'(y_first + w * s - 1);
		push_beat(KIND_CMD, OP_ROW_SET, '0, '0, 1'b0);
		push_beat(KIND_PARAM, x0[15:8], '0, '0, 1'b0);
		push_beat(KIND_PARAM, x0[7:0], '0, '0, 1'b0);
		push_beat(KIND_PARAM, x_end[15:8], '0, '0, 1'b0);
		push_beat(KIND_PARAM, x_end[7:0], '0, '0, 1'b0);
		push_beat(KIND_CMD, OP_COL_SET, '0, '0, 1'b0);
		push_beat(KIND_PARAM, y_first[15:8], '0, '0, 1'b0);
		push_beat(KIND_PARAM, y_first[7:0], '0, '0, 1'b0);
		push_beat(KIND_PARAM, y_end[15:8], '0, '0, 1'b0);
		push_beat(KIND_PARAM, y_end[7:0], '0, '0, 1'b0);
		push_beat(KIND_CMD, OP_MEM_WRITE, '0, '0, 1'b1);
	endfunction

	function automatic void render_row(logic [BITS_W-1:0] bits);
		int unsigned s;
		int unsigned w;
		int unsigned p;
		int unsigned c;
		logic [SCALE_W-1:0] rep;
		s = clamp_cfg(cfg_scale, SCALE_MAX);
		w = clamp_cfg(cfg_width, GLYPH_MAX);
		rep = s[SCALE_W-1:0];
		// msb of the used width goes first, the whole row repeats per scale step
		for (p = 0; p < s; p++)
			for (c = 0; c < w; c++)
				push_beat(KIND_PIXEL, '0, bits[w-1-c] ? cfg_text : cfg_back, rep,
					(p == s - 1) && (c == w - 1));
	endfunction

	function automatic int unsigned pick_gap(logic quiet);
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_item(logic cmd, logic [ADDR_W-1:0] x0, logic [ADDR_W-1:0] y0,
			logic [POS_W-1:0] pos, logic [BITS_W-1:0] bits, int unsigned gap);
		glyph_act_t a;
		a = '{act: ACT_ITEM, cmd: cmd, x0: x0, y0: y0, pos: pos, bits: bits,
			idx: '0, data: '0, gap: gap};
		glyph_work_q.push_back(a);
	endtask

	task automatic add_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		glyph_act_t a;
		a = '{act: ACT_REG_WRITE, cmd: 1'b0, x0: '0, y0: '0, pos: '0, bits: '0,
			idx: idx, data: data, gap: 0};
		glyph_work_q.push_back(a);
		if (idx == REG_GLYPH_HEIGHT)
			gen_height = 32'(data[GLYPH_W-1:0]);
	endtask

	task automatic add_settle();
		glyph_act_t a;
		a = '{act: ACT_SETTLE, cmd: 1'b0, x0: '0, y0: '0, pos: '0, bits: '0,
			idx: '0, data: '0, gap: 0};
		glyph_work_q.push_back(a);
	endtask

	// driver: one beat on the item port or one register write per step
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !item_took) begin
				// block still busy, hold the beat
			end else if (idle_left != 0) begin
				start <= 1'b0;
				wr_en <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (glyph_work_q.size() == 0) begin
				start <= 1'b0;
				wr_en <= 1'b0;
				feed_done <= 1'b1;
			end else begin
				step_now = glyph_work_q[0];
				case (step_now.act)
					ACT_ITEM: begin
						start <= 1'b1;
						wr_en <= 1'b0;
						command <= step_now.cmd;
						x_origin <= step_now.x0;
						y_origin <= step_now.y0;
						char_position <= step_now.pos;
						glyph_bits <= step_now.bits;
						idle_left <= step_now.gap;
						void'(glyph_work_q.pop_front());
					end
					ACT_REG_WRITE: begin
						start <= 1'b0;
						wr_en <= 1'b1;
						wr_index <= step_now.idx;
						wr_data <= step_now.data;
						void'(glyph_work_q.pop_front());
					end
					default: begin
						// registers change only once the stream has drained
						start <= 1'b0;
						wr_en <= 1'b0;
						if (display_stream_q.size() != 0 || busy) begin
							settle_cnt <= 0;
						end else if (settle_cnt == SETTLE_TICKS) begin
							settle_cnt <= 0;
							void'(glyph_work_q.pop_front());
						end else begin
							settle_cnt <= settle_cnt + 1;
						end
					end
				endcase
			end
		end
	end

	// monitor: register mirror, beat check, then prediction for a taken item
	always @(posedge clk) begin
		if (arst_n) begin
			item_took <= start && !busy;
			if (wr_en) begin
				writes_taken++;
				case (wr_index)
					REG_TEXT_COLOR:   cfg_text = wr_data;
					REG_BACK_COLOR:   cfg_back = wr_data;
					REG_SCALE:        cfg_scale = wr_data[SCALE_W-1:0];
					REG_GLYPH_WIDTH:  cfg_width = wr_data[GLYPH_W-1:0];
					REG_GLYPH_HEIGHT: cfg_height = wr_data[GLYPH_W-1:0];
					default: ;
				endcase
			end
			if (strobe) begin
				got_beat = '{kind, byte_value, pixel_color, repeat_res, last};
				if (display_stream_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat kind %0d byte %h colour %h repeat %0d last %b",
						$time, kind, byte_value, pixel_color, repeat_res, last);
				end else begin
					want_beat = display_stream_q.pop_front();
					beats_checked++;
					if (got_beat !== want_beat) begin
						errors++;
						$display("%0t: expected kind %0d byte %h colour %h repeat %0d last %b",
							$time, want_beat.kind, want_beat.byte_value, want_beat.color,
							want_beat.rep, want_beat.fin);
						$display("%0t:      got kind %0d byte %h colour %h repeat %0d last %b",
							$time, kind, byte_value, pixel_color, repeat_res, last);
					end
				end
			end
			if (start && !busy) begin
				items_taken++;
				if (command == CMD_BEGIN) begin
					windows_taken++;
					render_window(x_origin, y_origin, char_position);
				end else begin
					rows_taken++;
					render_row(glyph_bits);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, stall_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned rand_items;
		int unsigned phase_items;
		int unsigned rows;
		int unsigned r;
		logic quiet;
		logic [COLOR_W-1:0] tc;
		rand_items = 0;

		// reset settings: plain window, window wrapping at the top, rows
		// with unused high bits that must be ignored
		add_item(CMD_BEGIN, 16'h0000, 16'h0000, 8'd0, 16'($urandom), 0);
		add_item(CMD_BEGIN, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h0000, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'hFFFF, 1);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'hFF00, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h00A5, 2);

		// largest glyph at largest scale
		add_settle();
		add_write(REG_TEXT_COLOR, 16'h0000);
		add_write(REG_BACK_COLOR, 16'hFFFF);
		add_write(REG_SCALE, 16'd4);
		add_write(REG_GLYPH_WIDTH, 16'd16);
		add_write(REG_GLYPH_HEIGHT, 16'd16);
		add_item(CMD_BEGIN, 16'hFFFF, 16'hFFFF, 8'd255, 16'h0000, 0);
		add_item(CMD_ROW, 16'h0000, 16'h0000, 8'd0, 16'h8001, 0);
		add_item(CMD_ROW, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h0000, 5);

		// zero scale and sizes behave as one
		add_settle();
		add_write(REG_SCALE, 16'h0000);
		add_write(REG_GLYPH_WIDTH, 16'h0000);
		add_write(REG_GLYPH_HEIGHT, 16'h0000);
		add_write(REG_TEXT_COLOR, 16'hF81F);
		add_write(REG_BACK_COLOR, 16'h07E0);
		add_item(CMD_BEGIN, 16'h1234, 16'h0000, 8'd255, 16'hFFFF, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h0001, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'hFFFE, 0);

		// oversize values clamp, high data bits dropped, spare index ignored
		add_settle();
		add_write(REG_SCALE, 16'hFFFF);
		add_write(REG_GLYPH_WIDTH, 16'hFFFF);
		add_write(REG_GLYPH_HEIGHT, 16'hFFF1);
		add_write(REG_BEYOND, 16'hFFFF);
		add_write(REG_BEYOND + 3'd2, 16'h0000);
		add_item(CMD_BEGIN, 16'h0000, 16'hFFF0, 8'd3, 16'h0000, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h5555, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'hAAAA, 0);

		add_settle();
		add_write(REG_SCALE, 16'd5);
		add_write(REG_GLYPH_WIDTH, 16'd17);
		add_write(REG_GLYPH_HEIGHT, 16'd31);
		add_item(CMD_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 0);

		// smallest glyph
		add_settle();
		add_write(REG_SCALE, 16'd1);
		add_write(REG_GLYPH_WIDTH, 16'd1);
		add_write(REG_GLYPH_HEIGHT, 16'd1);
		add_item(CMD_BEGIN, 16'hFFFF, 16'h00FF, 8'd128, 16'($urandom), 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'hFFFE, 0);
		add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom), 16'h0001, 0);

		// random phases: mostly whole characters, some cut short, some noise
		while (rand_items < RANDOM_ITEMS) begin
			add_settle();
			tc = 16'($urandom);
			add_write(REG_TEXT_COLOR, tc);
			add_write(REG_BACK_COLOR, ($urandom_range(0, 9) == 0) ? tc : 16'($urandom));
			r = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			add_write(REG_SCALE, (16'($urandom) & 16'hFFF8) | 16'(r));
			r = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 16) : $urandom_range(0, 31);
			add_write(REG_GLYPH_WIDTH, (16'($urandom) & 16'hFFE0) | 16'(r));
			r = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 16) : $urandom_range(0, 31);
			add_write(REG_GLYPH_HEIGHT, (16'($urandom) & 16'hFFE0) | 16'(r));
			if ($urandom_range(0, 4) == 0)
				add_write(REG_BEYOND + 3'($urandom_range(0, 2)), 16'($urandom));
			quiet = ($urandom_range(0, 3) == 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS && rand_items + phase_items < RANDOM_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					add_item(CMD_BEGIN, 16'($urandom), 16'($urandom), 8'($urandom),
						16'($urandom), pick_gap(quiet));
					rows = clamp_cfg(gen_height, GLYPH_MAX);
					if (r >= 70)
						rows = $urandom_range(0, rows - 1);
					repeat (rows)
						add_item(CMD_ROW, 16'($urandom), 16'($urandom), 8'($urandom),
							16'($urandom), pick_gap(quiet));
					phase_items += rows + 1;
				end else begin
					add_item(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
						16'($urandom), pick_gap(quiet));
					phase_items++;
				end
			end
			rand_items += phase_items;
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (!feed_done || display_stream_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("%0d items taken: %0d character windows, %0d glyph rows; %0d beats checked",
			items_taken, windows_taken, rows_taken, beats_checked);
		$display("%0d register writes over several scale and glyph size settings, %0d errors",
			writes_taken, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
